### design/assert_macros.svh
// Assertion macros shared by the ordered key-value table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### design/okv_pkg.sv
// Package with the types and constants of the ordered key-value table.
`default_nettype none
package okv_pkg;

    localparam int KEY_W          = 32;
    localparam int VALUE_W        = 64;
    localparam int POS_W          = 4;
    localparam int COUNT_OUT_W    = 5;
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 64;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_UPDATE   = 3'd1,
        OP_UPSERT   = 3'd2,
        OP_ERASE    = 3'd3,
        OP_CONTAINS = 3'd4,
        OP_GET_KEY  = 3'd5,
        OP_GET_POS  = 3'd6
    } okv_op_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [KEY_W-1:0]   key_in;
        logic [VALUE_W-1:0] value_in;
        logic [POS_W-1:0]   position;
    } okv_req_t;

    typedef struct packed {
        logic                   success;
        logic [KEY_W-1:0]       key_out;
        logic [VALUE_W-1:0]     value_out;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   table_full;
    } okv_rsp_t;

    // Per-operation strobes broadcast from the controller to every cell.
    typedef struct packed {
        logic upd;
        logic ins;
        logic ers;
        logic rd_key;
        logic rd_pos;
    } okv_ctl_t;

endpackage
`default_nettype wire

### design/okv_stream_if.sv
// Valid/ready stream interface that carries one payload per transaction.
`default_nettype none
interface okv_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/okv_cell.sv
// One table entry of the cell chain: key/value storage, match and shift logic.
`default_nettype none
module okv_cell #(
    parameter int IDX        = 0,
    parameter int KEY_BITS   = okv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = okv_pkg::DEF_VALUE_BITS,
    parameter int CW         = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmp_en,
    input  wire logic [KEY_BITS-1:0]   cmp_key,
    input  wire logic [CW-1:0]         count,
    input  wire logic [okv_pkg::POS_W-1:0] position,
    input  wire okv_pkg::okv_ctl_t     ctl,
    input  wire logic [KEY_BITS-1:0]   wr_key,
    input  wire logic [VALUE_BITS-1:0] wr_value,
    input  wire logic [KEY_BITS-1:0]   next_key,
    input  wire logic [VALUE_BITS-1:0] next_value,
    input  wire logic                  hit_in,
    output logic                       hit_out,
    input  wire logic [KEY_BITS-1:0]   rd_key_in,
    input  wire logic [VALUE_BITS-1:0] rd_value_in,
    output logic [KEY_BITS-1:0]        rd_key_out,
    output logic [VALUE_BITS-1:0]      rd_value_out,
    output logic [KEY_BITS-1:0]        key,
    output logic [VALUE_BITS-1:0]      value,
    output logic                       match
);
    import okv_pkg::*;

    localparam int PCW = (CW > POS_W) ? CW : POS_W;

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  match_reg;
    logic                  occupied;
    logic                  pos_hit;
    logic                  sel;

    assign occupied = (CW'(IDX) < count);
    assign pos_hit  = (PCW'(IDX) == PCW'(position));
    assign sel      = (ctl.rd_key & match_reg) | (ctl.rd_pos & pos_hit & occupied);

    // The hit chain tells each cell whether the erased entry sits at or below it.
    assign hit_out      = hit_in | match_reg;
    assign rd_key_out   = rd_key_in | (sel ? key_reg : '0);
    assign rd_value_out = rd_value_in | (sel ? value_reg : '0);

    assign key   = key_reg;
    assign value = value_reg;
    assign match = match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (cmp_en)
        begin
            match_reg <= occupied && (key_reg == cmp_key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ers && hit_out)
        begin
            key_reg   <= next_key;
            value_reg <= next_value;
        end
        else if (ctl.ins && (CW'(IDX) == count))
        begin
            key_reg   <= wr_key;
            value_reg <= wr_value;
        end
        else if (ctl.upd && match_reg)
        begin
            value_reg <= wr_value;
        end
    end
endmodule
`default_nettype wire

### design/ordered_key_value_table.sv
// Top level of the ordered key-value table: controller and chain of entry cells.
// The accept edge loads the match bits of all cells. In ST_EXEC, once the result
// register is empty or being read, the retiring edge applies the operation and
// registers the result. A new request is accepted only in ST_IDLE, once the
// previous one has retired.
// Reset clears the entry count, the controller state and the result valid flag.
`default_nettype none
`include "assert_macros.svh"
module ordered_key_value_table #(
    parameter int CAPACITY   = okv_pkg::DEF_CAPACITY,
    parameter int KEY_BITS   = okv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = okv_pkg::DEF_VALUE_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    okv_stream_if.sink   req,
    okv_stream_if.source rsp
);
    import okv_pkg::*;

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PCW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            out_valid_reg;
    okv_rsp_t        out_reg;

    logic [2:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [POS_W-1:0]      pos_reg;

    logic     accept;
    logic     exec_fire;
    logic     found;
    logic     room;
    logic     pos_ok;
    logic     ins_ok;
    logic     full_flag;
    logic     ok;
    okv_ctl_t rd_ctl;
    okv_ctl_t ctl;
    okv_rsp_t result;

    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [KEY_BITS-1:0]   nxt_key    [CAPACITY];
    logic [VALUE_BITS-1:0] nxt_value  [CAPACITY];
    logic [CAPACITY-1:0]   match_vec;
    logic [CAPACITY:0]     hit_chain;
    logic [KEY_BITS-1:0]   rdk_chain  [CAPACITY+1];
    logic [VALUE_BITS-1:0] rdv_chain  [CAPACITY+1];

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    assign hit_chain[0] = 1'b0;
    assign rdk_chain[0] = '0;
    assign rdv_chain[0] = '0;
    assign found        = hit_chain[CAPACITY];
    assign room         = (count_reg < CW'(CAPACITY));
    assign pos_ok       = (PCW'(pos_reg) < PCW'(count_reg));

    always_comb
    begin
        rd_ctl    = '0;
        ins_ok    = 1'b0;
        full_flag = 1'b0;
        ok        = 1'b0;
        case (op_reg)
            OP_INSERT:
            begin
                ins_ok    = !found && room;
                full_flag = !found && !room;
                ok        = ins_ok;
            end
            OP_UPDATE:
            begin
                rd_ctl.upd = found;
                ok         = found;
            end
            OP_UPSERT:
            begin
                rd_ctl.upd = found;
                ins_ok     = !found && room;
                full_flag  = !found && !room;
                ok         = found || ins_ok;
            end
            OP_ERASE:
            begin
                rd_ctl.ers = found;
                ok         = found;
            end
            OP_CONTAINS:
            begin
                ok = found;
            end
            OP_GET_KEY:
            begin
                rd_ctl.rd_key = 1'b1;
                ok            = found;
            end
            OP_GET_POS:
            begin
                rd_ctl.rd_pos = 1'b1;
                ok            = pos_ok;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        rd_ctl.ins = ins_ok;
    end

    // Table writes happen only on the edge that retires the transaction.
    always_comb
    begin
        ctl        = rd_ctl;
        ctl.upd    = rd_ctl.upd && exec_fire;
        ctl.ins    = rd_ctl.ins && exec_fire;
        ctl.ers    = rd_ctl.ers && exec_fire;
        count_next = count_reg;
        if (rd_ctl.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd_ctl.ers)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        result.success     = ok;
        result.key_out     = (op_reg == OP_GET_POS) ? KEY_W'(rdk_chain[CAPACITY]) : '0;
        result.value_out   = VALUE_W'(rdv_chain[CAPACITY]);
        result.entry_count = COUNT_OUT_W'(count_next);
        result.table_full  = full_flag;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == CAPACITY - 1)
            begin : g_last
                assign nxt_key[i]   = cell_key[i];
                assign nxt_value[i] = cell_value[i];
            end
            else
            begin : g_mid
                assign nxt_key[i]   = cell_key[i+1];
                assign nxt_value[i] = cell_value[i+1];
            end

            okv_cell #(
                .IDX        (i),
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS),
                .CW         (CW)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cmp_en       (accept),
                .cmp_key      (KEY_BITS'(req.payload.key_in)),
                .count        (count_reg),
                .position     (pos_reg),
                .ctl          (ctl),
                .wr_key       (key_reg),
                .wr_value     (value_reg),
                .next_key     (nxt_key[i]),
                .next_value   (nxt_value[i]),
                .hit_in       (hit_chain[i]),
                .hit_out      (hit_chain[i+1]),
                .rd_key_in    (rdk_chain[i]),
                .rd_value_in  (rdv_chain[i]),
                .rd_key_out   (rdk_chain[i+1]),
                .rd_value_out (rdv_chain[i+1]),
                .key          (cell_key[i]),
                .value        (cell_value[i]),
                .match        (match_vec[i])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.payload.opcode;
            key_reg   <= KEY_BITS'(req.payload.key_in);
            value_reg <= VALUE_BITS'(req.payload.value_in);
            pos_reg   <= req.payload.position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                    if (rsp.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    if (exec_fire)
                    begin
                        state_reg     <= ST_IDLE;
                        count_reg     <= count_next;
                        out_valid_reg <= 1'b1;
                        out_reg       <= result;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY))
    `ASSERT_SAME(a_unique_match, clk, rst_n, state_reg == ST_EXEC, $onehot0(match_vec))
    `ASSERT_SAME(a_full_only_at_cap, clk, rst_n, exec_fire && full_flag,
                 count_reg == CW'(CAPACITY))
    `ASSERT_NEXT(a_insert_grows, clk, rst_n, ctl.ins,
                 count_reg == $past(count_reg) + CW'(1))
    `ASSERT_NEXT(a_result_posted, clk, rst_n, exec_fire,
                 out_valid_reg && state_reg == ST_IDLE)
endmodule
`default_nettype wire
